### src/ipv4fr_pkg.sv
// Shared types, constants and codes for the IPv4 fragment reassembly tracker.
// No dependencies.
package ipv4fr_pkg;

    localparam int NUM_CONTEXTS_DEF = 8;
    localparam int MAX_FRAGS_DEF    = 16;

    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
    localparam logic [17:0] RECV_MAX      = 18'h3FFFF;
    localparam logic [16:0] DGRAM_MAX     = 17'd65535;

    localparam logic [2:0] ST_IN_PROGRESS = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_INVALID     = 3'd2;
    localparam logic [2:0] ST_DUPLICATE   = 3'd3;
    localparam logic [2:0] ST_TOO_BIG     = 3'd4;
    localparam logic [2:0] ST_NO_ROOM     = 3'd5;

    localparam logic [0:0] REG_TIMEOUT = 1'd0;

    typedef struct packed {
        logic        mode;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ident;
        logic [7:0]  protocol;
        logic [7:0]  iface_index;
        logic [12:0] frag_offset;
        logic        more_frags;
        logic [15:0] payload_len;
        logic [5:0]  header_len;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [15:0] datagram_len;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_MATCH,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN,
        S_FINISH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;       // capture input word
        logic tick;       // age all contexts
        logic match;      // resolve slot and allocate
        logic check;      // end checks and length update
        logic scan_rd;    // issue offset read
        logic scan_step;  // compare one stored offset
        logic finish;     // store offset, decide completion
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic rejected;   // result already decided
        logic scan_done;
    } t_sts;

endpackage

### src/ipv4fr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ipv4fr_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### src/ipv4fr_ctrl.sv
// Controller state machine for the fragment tracker.
// Depends on ipv4fr_pkg.
module ipv4fr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ipv4fr_pkg::t_sts    i_sts,
    output ipv4fr_pkg::t_cmd    o_cmd
);
    ipv4fr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4fr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipv4fr_pkg::S_IDLE:    if (i_in_valid) n_state = ipv4fr_pkg::S_MATCH;
            ipv4fr_pkg::S_MATCH: begin
                if (i_sts.is_tick) n_state = ipv4fr_pkg::S_TICK;
                else n_state = ipv4fr_pkg::S_CHECK;
            end
            ipv4fr_pkg::S_TICK:    n_state = ipv4fr_pkg::S_IDLE;
            ipv4fr_pkg::S_CHECK:   n_state = ipv4fr_pkg::S_SCAN_RD;
            ipv4fr_pkg::S_SCAN_RD: begin
                if (i_sts.rejected) n_state = ipv4fr_pkg::S_OUT;
                else if (i_sts.scan_done) n_state = ipv4fr_pkg::S_FINISH;
                else n_state = ipv4fr_pkg::S_SCAN;
            end
            ipv4fr_pkg::S_SCAN:    n_state = ipv4fr_pkg::S_SCAN_RD;
            ipv4fr_pkg::S_FINISH:  n_state = ipv4fr_pkg::S_OUT;
            ipv4fr_pkg::S_OUT:     if (!i_out_stall) n_state = ipv4fr_pkg::S_IDLE;
            default:               n_state = ipv4fr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ipv4fr_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ipv4fr_pkg::S_MATCH:   o_cmd.match = !i_sts.is_tick;
            ipv4fr_pkg::S_TICK:    o_cmd.tick = 1'b1;
            ipv4fr_pkg::S_CHECK:   o_cmd.check = 1'b1;
            ipv4fr_pkg::S_SCAN_RD: o_cmd.scan_rd = 1'b1;
            ipv4fr_pkg::S_SCAN:    o_cmd.scan_step = 1'b1;
            ipv4fr_pkg::S_FINISH:  o_cmd.finish = 1'b1;
            ipv4fr_pkg::S_OUT:     o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

### src/ipv4fr_dp.sv
// Datapath: context table, length checks, offset list scan and aging.
// Depends on ipv4fr_pkg and ipv4fr_ram.
module ipv4fr_dp #(
    parameter int NUM_CONTEXTS = ipv4fr_pkg::NUM_CONTEXTS_DEF,
    parameter int MAX_FRAGS    = ipv4fr_pkg::MAX_FRAGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipv4fr_pkg::t_in_word  i_in,
    input  logic [31:0]           i_timeout,
    input  ipv4fr_pkg::t_cmd      i_cmd,
    output ipv4fr_pkg::t_sts      o_sts,
    output ipv4fr_pkg::t_out_word o_out
);
    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int FW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int NW = $clog2(MAX_FRAGS + 1);
    localparam int DEPTH = NUM_CONTEXTS * MAX_FRAGS;
    localparam int AW = $clog2(DEPTH);

    ipv4fr_pkg::t_in_word r_in;

    logic [NUM_CONTEXTS-1:0] r_valid;
    logic [31:0] r_src [NUM_CONTEXTS];
    logic [31:0] r_dst [NUM_CONTEXTS];
    logic [31:0] r_key [NUM_CONTEXTS];
    logic [16:0] r_end [NUM_CONTEXTS];
    logic [17:0] r_recv [NUM_CONTEXTS];
    logic [1:0]  r_flags [NUM_CONTEXTS];
    logic [31:0] r_age [NUM_CONTEXTS];
    logic [NW-1:0] r_cnt [NUM_CONTEXTS];

    logic [CW-1:0] r_slot;
    logic          r_rej;
    logic [2:0]    r_status;
    logic [15:0]   r_len;
    logic [NW-1:0] r_idx;

    logic [31:0] key3;
    logic [16:0] offset, end_raw, end_v;
    logic [NUM_CONTEXTS-1:0] hit;
    logic          found, free_found;
    logic [CW-1:0] hit_idx, free_idx;
    logic [AW-1:0] ram_addr;
    logic [12:0]   ram_rdata;
    logic          ram_we;
    logic [17:0]   recv_sum;
    logic [17:0]   recv_cur;
    logic [17:0]   dlen;
    logic          done;

    assign key3 = {r_in.ident, r_in.protocol, r_in.iface_index};
    assign offset = {1'b0, r_in.frag_offset, 3'b000};
    assign end_raw = offset + {1'b0, r_in.payload_len};
    assign end_v = r_in.more_frags ? {end_raw[16:3], 3'b000} : end_raw;

    always_comb begin
        found = 1'b0;
        hit_idx = '0;
        free_found = 1'b0;
        free_idx = '0;
        for (int i = NUM_CONTEXTS - 1; i >= 0; i--) begin
            hit[i] = r_valid[i] && r_src[i] == r_in.src_addr &&
                     r_dst[i] == r_in.dst_addr && r_key[i] == key3;
            if (hit[i]) begin
                found = 1'b1;
                hit_idx = CW'(i);
            end
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx = CW'(i);
            end
        end
    end

    assign recv_cur = r_recv[r_slot];
    assign recv_sum = (19'(recv_cur) + 19'(end_v - offset) > 19'(ipv4fr_pkg::RECV_MAX)) ?
                      ipv4fr_pkg::RECV_MAX : 18'(19'(recv_cur) + 19'(end_v - offset));
    assign dlen = 18'(r_in.header_len) + r_recv[r_slot];
    assign done = r_flags[r_slot] == 2'b11 && r_recv[r_slot] == {1'b0, r_end[r_slot]};

    assign ram_we = i_cmd.finish && r_status == ipv4fr_pkg::ST_IN_PROGRESS;
    assign ram_addr = AW'(r_slot) * AW'(MAX_FRAGS) + AW'(r_idx[FW-1:0]);

    ipv4fr_ram #(.WIDTH(13), .DEPTH(DEPTH)) u_offsets (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_in.frag_offset),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.tick) begin
                for (int i = 0; i < NUM_CONTEXTS; i++) begin
                    if (r_valid[i]) begin
                        if (r_age[i] != 32'hFFFF_FFFF) begin
                            if (r_age[i] + 32'd1 >= i_timeout) r_valid[i] <= 1'b0;
                        end else if (r_age[i] >= i_timeout) begin
                            r_valid[i] <= 1'b0;
                        end
                    end
                end
            end
            if (i_cmd.match && !found && free_found) r_valid[free_idx] <= 1'b1;
            // free the context once the datagram is whole
            if (ram_we && done) begin
                r_valid[r_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.tick) begin
            for (int i = 0; i < NUM_CONTEXTS; i++) begin
                if (r_valid[i] && r_age[i] != 32'hFFFF_FFFF) r_age[i] <= r_age[i] + 32'd1;
            end
        end
        if (i_cmd.match) begin
            r_rej <= 1'b0;
            r_status <= ipv4fr_pkg::ST_IN_PROGRESS;
            r_len <= '0;
            r_idx <= '0;
            if (found) begin
                r_slot <= hit_idx;
            end else if (free_found) begin
                r_slot <= free_idx;
                r_src[free_idx] <= r_in.src_addr;
                r_dst[free_idx] <= r_in.dst_addr;
                r_key[free_idx] <= key3;
                r_end[free_idx] <= '0;
                r_recv[free_idx] <= '0;
                r_flags[free_idx] <= '0;
                r_age[free_idx] <= '0;
                r_cnt[free_idx] <= '0;
            end else begin
                r_slot <= '0;
                r_rej <= 1'b1;
                r_status <= ipv4fr_pkg::ST_NO_ROOM;
            end
        end
        if (i_cmd.check && !r_rej) begin
            if (!r_in.more_frags) begin
                if (end_v < r_end[r_slot] ||
                    (r_flags[r_slot][1] && end_v != r_end[r_slot])) begin
                    r_rej <= 1'b1;
                    r_status <= ipv4fr_pkg::ST_INVALID;
                end else if (end_v == offset) begin
                    r_flags[r_slot][1] <= 1'b1;
                    r_end[r_slot] <= end_v;
                    r_rej <= 1'b1;
                    r_status <= ipv4fr_pkg::ST_INVALID;
                end else begin
                    r_flags[r_slot] <= {1'b1, r_flags[r_slot][0] | (offset == '0)};
                    r_end[r_slot] <= end_v;
                    r_recv[r_slot] <= recv_sum;
                end
            end else begin
                if (end_v > r_end[r_slot] && r_flags[r_slot][1]) begin
                    r_rej <= 1'b1;
                    r_status <= ipv4fr_pkg::ST_INVALID;
                end else begin
                    if (end_v > r_end[r_slot]) r_end[r_slot] <= end_v;
                    if (end_v == offset) begin
                        r_rej <= 1'b1;
                        r_status <= ipv4fr_pkg::ST_INVALID;
                    end else begin
                        if (offset == '0) r_flags[r_slot][0] <= 1'b1;
                        r_recv[r_slot] <= recv_sum;
                    end
                end
            end
        end
        // ram read was issued in SCAN_RD; compare the returned offset
        if (i_cmd.scan_step) begin
            if (ram_rdata == r_in.frag_offset) begin
                r_rej <= 1'b1;
                r_status <= ipv4fr_pkg::ST_DUPLICATE;
            end else begin
                r_idx <= r_idx + NW'(1);
            end
        end
        if (i_cmd.scan_rd && !r_rej && o_sts.scan_done &&
            r_cnt[r_slot] >= NW'(MAX_FRAGS)) begin
            r_rej <= 1'b1;
            r_status <= ipv4fr_pkg::ST_NO_ROOM;
        end
        if (ram_we) begin
            r_cnt[r_slot] <= r_cnt[r_slot] + NW'(1);
            if (done) begin
                if (dlen > {1'b0, ipv4fr_pkg::DGRAM_MAX}) begin
                    r_status <= ipv4fr_pkg::ST_TOO_BIG;
                end else begin
                    r_status <= ipv4fr_pkg::ST_COMPLETE;
                    r_len <= dlen[15:0];
                end
            end
        end
    end

    assign o_sts.is_tick = r_in.mode;
    assign o_sts.rejected = r_rej;
    assign o_sts.scan_done = r_idx >= r_cnt[r_slot];

    assign o_out.status = r_status;
    assign o_out.slot = 3'(r_slot);
    assign o_out.datagram_len = r_len;
endmodule

### src/ipv4_fragment_reassembly_tracker.sv
// Top level of the IPv4 fragment reassembly tracker: APB register, controller, datapath.
// Depends on ipv4fr_pkg, ipv4fr_ctrl, ipv4fr_dp.
//
// Takes one word at a time: a fragment or a tick. A tick ages all contexts and
// gives no result. A fragment passes MATCH, CHECK and then the scan of the offset
// RAM, which reads and compares the N offsets already stored for its context (at
// most MAX_FRAGS) one entry at a time, then FINISH and OUT, where it waits while the
// output is stalled. A fragment rejected before the scan goes from SCAN_RD to OUT,
// and a duplicate of stored entry k (from 0) ends the scan at that entry.
// Register 0 at byte address 0 holds timeout_ticks (reset 30000).
module ipv4_fragment_reassembly_tracker #(
    parameter int NUM_CONTEXTS = ipv4fr_pkg::NUM_CONTEXTS_DEF,
    parameter int MAX_FRAGS    = ipv4fr_pkg::MAX_FRAGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ipv4fr_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output ipv4fr_pkg::t_out_word o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [0:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [31:0] r_timeout;
    ipv4fr_pkg::t_cmd cmd;
    ipv4fr_pkg::t_sts sts;

    assign pready = 1'b1;
    assign prdata = (paddr == ipv4fr_pkg::REG_TIMEOUT) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= ipv4fr_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && paddr == ipv4fr_pkg::REG_TIMEOUT) begin
            r_timeout <= pwdata;
        end
    end

    ipv4fr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .o_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ipv4fr_dp #(.NUM_CONTEXTS(NUM_CONTEXTS), .MAX_FRAGS(MAX_FRAGS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_data),
        .i_timeout(r_timeout),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_out    (o_data)
    );
endmodule
